@@ hdl/buddy_page_allocator_defines.svh @@
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`else
`define BPA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/bpa_pkg.sv @@
package bpa_pkg;

  localparam int NUM_ORDERS  = 11;
  localparam int TOTAL_PAGES = 4096;
  localparam int TOP_ORDER   = NUM_ORDERS - 1;
  localparam int ORD_W       = $clog2(NUM_ORDERS);
  localparam int PAGE_W      = $clog2(TOTAL_PAGES);
  localparam int CNT_W       = PAGE_W + 1;
  localparam int WORD_W      = 64;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int WIDX_W      = PAGE_W - BIT_W;

  // words of free bits held for one order
  function automatic int words_at(int k);
    int blocks;
    blocks = TOTAL_PAGES >> k;
    return (blocks + WORD_W - 1) >> BIT_W;
  endfunction

  // first word of one order in the bitmap memory
  function automatic int base_of(int k);
    int sum;
    sum = 0;
    for (int j = 0; j < k; j++) sum += words_at(j);
    return sum;
  endfunction

  localparam int MEM_DEPTH = base_of(NUM_ORDERS);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [CNT_W-1:0] SIZE_LIMIT = CNT_W'(1) << TOP_ORDER;
  localparam logic [CNT_W-1:0] PAGES_MAX  = CNT_W'(TOTAL_PAGES);

  typedef enum logic [3:0] {
    ST_REB_INIT, ST_REB_RUN, ST_IDLE, ST_DECODE, ST_SCAN_RD, ST_SCAN_CHK,
    ST_CLR_RD, ST_CLR_WR, ST_SPLIT_CHK, ST_SET_RD, ST_SET_WR,
    ST_FREE_RD, ST_FREE_WR, ST_RESP
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_PREP, DP_REB_INIT, DP_REB_WR, DP_SCAN_CHK,
    DP_WR_CLR, DP_WR_SET, DP_WR_MERGE, DP_SPLIT, DP_RESP
  } dp_op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_TOO_BIG = 2'd1,
    STS_NONE    = 2'd2,
    STS_FREED   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
    logic    cfg_load;
  } dp_cmd_t;

  typedef struct packed {
    logic too_large;
    logic is_free;
    logic none_free;
    logic reb_last;
    logic word_nz;
    logic k_gt_ord;
    logic merge_hit;
  } dp_sts_t;

  function automatic logic [ADDR_W-1:0] word_addr(logic [ORD_W-1:0] k,
                                                  logic [WIDX_W-1:0] w);
    logic [ADDR_W-1:0] base;
    base = '0;
    for (int j = 0; j < NUM_ORDERS; j++)
      if (k == ORD_W'(j)) base = ADDR_W'(base_of(j));
    return base + ADDR_W'(w);
  endfunction

  function automatic logic [WIDX_W-1:0] last_word(logic [ORD_W-1:0] k);
    logic [WIDX_W-1:0] lw;
    lw = '0;
    for (int j = 0; j < NUM_ORDERS; j++)
      if (k == ORD_W'(j)) lw = WIDX_W'(words_at(j) - 1);
    return lw;
  endfunction

  // ceiling log2, zero and one give order 0
  function automatic logic [ORD_W-1:0] order_of(logic [PAGE_W-1:0] cnt);
    logic [PAGE_W-1:0] m;
    logic [ORD_W-1:0]  ord;
    m   = cnt - PAGE_W'(1);
    ord = '0;
    for (int b = 0; b < PAGE_W; b++)
      if (m[b]) ord = ORD_W'(b + 1);
    if (cnt <= PAGE_W'(1)) ord = '0;
    return ord;
  endfunction

  function automatic logic [BIT_W-1:0] low_bit(logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_W - 1; b >= 0; b--)
      if (w[b]) p = BIT_W'(b);
    return p;
  endfunction

endpackage

@@ hdl/bpa_ram.sv @@
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/bpa_ctrl.sv @@
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cfg_valid_i,
  input  bpa_pkg::dp_sts_t  sts_i,
  output bpa_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              cfg_ready_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;
  // order search outcome, held from decode until the response
  logic   miss_q, miss_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_REB_INIT;
      miss_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      miss_q  <= miss_d;
    end
  end

  assign miss_d = (state_q == ST_DECODE) ? sts_i.none_free : miss_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_REB_INIT: state_d = ST_REB_RUN;
      ST_REB_RUN:  if (sts_i.reb_last) state_d = ST_IDLE;
      ST_IDLE: begin
        priority if (cfg_valid_i && !start_i) state_d = ST_REB_INIT;
        else if (start_i)                     state_d = ST_DECODE;
        else                                  state_d = ST_IDLE;
      end
      ST_DECODE: begin
        priority if (sts_i.too_large) state_d = ST_RESP;
        else if (sts_i.is_free)       state_d = ST_FREE_RD;
        else if (sts_i.none_free)     state_d = ST_RESP;
        else                          state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD:   state_d = ST_SCAN_CHK;
      ST_SCAN_CHK:  state_d = sts_i.word_nz ? ST_CLR_RD : ST_SCAN_RD;
      ST_CLR_RD:    state_d = ST_CLR_WR;
      ST_CLR_WR:    state_d = ST_SPLIT_CHK;
      ST_SPLIT_CHK: state_d = sts_i.k_gt_ord ? ST_SET_RD : ST_RESP;
      ST_SET_RD:    state_d = ST_SET_WR;
      ST_SET_WR:    state_d = ST_SPLIT_CHK;
      ST_FREE_RD:   state_d = ST_FREE_WR;
      ST_FREE_WR:   state_d = sts_i.merge_hit ? ST_FREE_RD : ST_RESP;
      ST_RESP:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '{op: DP_NOP, code: STS_OK, cfg_load: 1'b0};
    unique case (state_q)
      ST_REB_INIT: cmd_o.op = DP_REB_INIT;
      ST_REB_RUN:  cmd_o.op = DP_REB_WR;
      ST_IDLE: begin
        priority if (cfg_valid_i && !start_i) cmd_o.cfg_load = 1'b1;
        else if (start_i)                     cmd_o.op = DP_LOAD;
        else                                  cmd_o.op = DP_NOP;
      end
      ST_DECODE:    cmd_o.op = DP_PREP;
      ST_SCAN_CHK:  cmd_o.op = DP_SCAN_CHK;
      ST_CLR_WR:    cmd_o.op = DP_WR_CLR;
      ST_SPLIT_CHK: if (sts_i.k_gt_ord) cmd_o.op = DP_SPLIT;
      ST_SET_WR:    cmd_o.op = DP_WR_SET;
      ST_FREE_WR:   cmd_o.op = DP_WR_MERGE;
      ST_RESP: begin
        cmd_o.op = DP_RESP;
        priority if (sts_i.too_large) cmd_o.code = STS_TOO_BIG;
        else if (sts_i.is_free)       cmd_o.code = STS_FREED;
        else if (miss_q)              cmd_o.code = STS_NONE;
        else                          cmd_o.code = STS_OK;
      end
      default: cmd_o.op = DP_NOP;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_i;

endmodule

@@ hdl/bpa_dp.sv @@
`include "buddy_page_allocator_defines.svh"

module bpa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bpa_pkg::dp_cmd_t                  cmd_i,
  output bpa_pkg::dp_sts_t                  sts_o,
  input  logic                              kind_i,
  input  logic [bpa_pkg::PAGE_W-1:0]        page_count_i,
  input  logic [bpa_pkg::PAGE_W-1:0]        page_number_i,
  input  logic [bpa_pkg::CNT_W-1:0]         cfg_total_pages_i,
  output logic [bpa_pkg::PAGE_W-1:0]        block_page_o,
  output logic [1:0]                        status_o,
  output logic                              done_o
);
  import bpa_pkg::*;

  logic [CNT_W-1:0]  n_q;
  logic              kind_q;
  logic              too_large_q;
  logic [ORD_W-1:0]  ord_q;
  logic [PAGE_W-1:0] page_q;
  logic [ORD_W-1:0]  k_q;
  logic [PAGE_W-1:0] idx_q;
  logic [PAGE_W-1:0] res_q;
  logic [CNT_W-1:0]  cnt_q [NUM_ORDERS];
  logic              valid_q;
  logic [1:0]        status_q;
  logic [PAGE_W-1:0] out_page_q;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en;
  logic [ADDR_W-1:0] addr;
  logic [WIDX_W-1:0] widx;
  logic [BIT_W-1:0]  bpos;
  logic [WORD_W-1:0] bmask;
  logic [WORD_W-1:0] buddy_mask;
  logic [WORD_W-1:0] set_word;
  logic              old_bit;
  logic              hit;
  logic [CNT_W-1:0]  cur_cnt;
  logic [WORD_W-1:0] reb_word;
  logic [CNT_W-1:0]  top_cnt;
  logic [PAGE_W-1:0] part_idx;
  logic [ORD_W-1:0]  first;
  logic              found;
  logic [PAGE_W-1:0] found_idx;

  assign widx       = idx_q[PAGE_W-1:BIT_W];
  assign addr       = word_addr(k_q, widx);
  assign bpos       = idx_q[BIT_W-1:0];
  assign bmask      = WORD_W'(1) << bpos;
  assign buddy_mask = WORD_W'(1) << (bpos ^ BIT_W'(1));
  assign set_word   = rd_data | bmask;
  assign old_bit    = rd_data[bpos];
  assign hit        = (k_q != ORD_W'(TOP_ORDER)) && set_word[bpos ^ BIT_W'(1)];
  assign cur_cnt    = cnt_q[k_q];
  assign found_idx  = {widx, low_bit(rd_data)};

  // rebuild pattern: top order gets a run from block 0, lower orders at most one block
  assign top_cnt  = n_q >> TOP_ORDER;
  assign part_idx = PAGE_W'(n_q >> k_q) & ~PAGE_W'(1);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      if (k_q == ORD_W'(TOP_ORDER)) begin
        reb_word[b] = {1'b0, widx, BIT_W'(b)} < top_cnt;
      end else begin
        reb_word[b] = n_q[k_q] && (part_idx == {widx, BIT_W'(b)});
      end
    end
  end

  // lowest order at or above the request that holds a free block
  always_comb begin
    first = '0;
    found = 1'b0;
    for (int r = NUM_ORDERS - 1; r >= 0; r--) begin
      if (ORD_W'(r) >= ord_q && cnt_q[r] != '0) begin
        first = ORD_W'(r);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = set_word;
    unique case (cmd_i.op)
      DP_REB_WR: begin
        wr_en   = 1'b1;
        wr_data = reb_word;
      end
      DP_WR_CLR: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~bmask;
      end
      DP_WR_SET: begin
        wr_en   = 1'b1;
        wr_data = set_word;
      end
      DP_WR_MERGE: begin
        wr_en   = 1'b1;
        wr_data = hit ? (set_word & ~(bmask | buddy_mask)) : set_word;
      end
      default: wr_en = 1'b0;
    endcase
  end

  bpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEM_DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(addr),
    .wdata_i(wr_data),
    .raddr_i(addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= PAGES_MAX;
      k_q     <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
      for (int k = 0; k < NUM_ORDERS; k++) cnt_q[k] <= '0;
    end else begin
      valid_q <= (cmd_i.op == DP_RESP);
      if (cmd_i.cfg_load) begin
        n_q <= (cfg_total_pages_i > PAGES_MAX) ? PAGES_MAX : cfg_total_pages_i;
      end
      unique case (cmd_i.op)
        DP_PREP: begin
          if (kind_q == KIND_FREE) begin
            k_q   <= ord_q;
            idx_q <= page_q >> ord_q;
          end else begin
            k_q   <= first;
            idx_q <= '0;
          end
        end
        DP_REB_INIT: begin
          for (int k = 0; k < NUM_ORDERS; k++) begin
            cnt_q[k] <= (k == TOP_ORDER) ? top_cnt : CNT_W'(n_q[k]);
          end
          k_q   <= ORD_W'(TOP_ORDER);
          idx_q <= '0;
        end
        DP_REB_WR: begin
          if (widx == last_word(k_q)) begin
            k_q   <= k_q - ORD_W'(1);
            idx_q <= '0;
          end else begin
            idx_q <= idx_q + PAGE_W'(WORD_W);
          end
        end
        DP_SCAN_CHK: begin
          if (rd_data != '0) begin
            idx_q <= found_idx;
          end else begin
            idx_q <= idx_q + PAGE_W'(WORD_W);
          end
        end
        DP_WR_CLR: cnt_q[k_q] <= cur_cnt - CNT_W'(old_bit);
        DP_WR_SET: cnt_q[k_q] <= cur_cnt + CNT_W'(!old_bit);
        DP_WR_MERGE: begin
          cnt_q[k_q] <= cur_cnt + CNT_W'(!old_bit) - (hit ? CNT_W'(2) : CNT_W'(0));
          if (hit) begin
            k_q   <= k_q + ORD_W'(1);
            idx_q <= idx_q >> 1;
          end
        end
        DP_SPLIT: begin
          k_q   <= k_q - ORD_W'(1);
          idx_q <= (res_q >> (k_q - ORD_W'(1))) + PAGE_W'(1);
        end
        default: ;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_LOAD: begin
        kind_q      <= kind_i;
        too_large_q <= {1'b0, page_count_i} > SIZE_LIMIT;
        ord_q       <= order_of(page_count_i);
        page_q      <= page_number_i;
        res_q       <= '0;
      end
      DP_SCAN_CHK: begin
        if (rd_data != '0) res_q <= found_idx << k_q;
      end
      DP_RESP: begin
        status_q   <= cmd_i.code;
        out_page_q <= res_q;
      end
      default: ;
    endcase
  end

  assign sts_o = '{
    too_large: too_large_q,
    is_free:   kind_q,
    none_free: !found,
    reb_last:  (k_q == '0) && (widx == last_word(k_q)),
    word_nz:   rd_data != '0,
    k_gt_ord:  k_q > ord_q,
    merge_hit: hit
  };

  assign block_page_o = out_page_q;
  assign status_o     = status_q;
  assign done_o       = valid_q;

  `BPA_ASSERT_IMPLIES(a_clr_has_free, clk_i, rst_ni, cmd_i.op == DP_WR_CLR, cur_cnt != '0)
  `BPA_ASSERT_IMPLIES(a_split_above, clk_i, rst_ni, cmd_i.op == DP_SPLIT, k_q > ord_q)
  `BPA_ASSERT_NEXT(a_done_single, clk_i, rst_ni, valid_q, !valid_q)

endmodule

@@ hdl/buddy_page_allocator.sv @@
// buddy page allocator over per-order free bitmaps
// request channel: drive kind_i, page_count_i and page_number_i with start_i;
// the transaction is taken at a clock edge where start_i is high and busy_o
// is low. kind 0 allocates, kind 1 frees a block
// result channel: done_o pulses for one cycle with block_page_o and status_o;
// the receiver cannot stall, so it must take the result in that cycle
// config channel: cfg_total_pages_i with cfg_valid_i / cfg_ready_o; a write
// sets the managed page count (saturated) and rebuilds the free bitmaps
// a free reads and writes back one bitmap word per order visited while
// merging (up to 11); an allocate scans the 64-bit words at the chosen order
// (up to 64 at order 0), clears the found bit, then sets one buddy bit per
// split; a rejected or unserved request goes from decode straight to the
// response. the bitmap memory has one shared address and a registered read
// one request is in flight at a time
// reset and every config write run a rebuild pass, a setup step and then one
// bitmap word per cycle, 131 words, with busy_o high and no requests taken
module buddy_page_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  page_count_i,
  input  logic [bpa_pkg::PAGE_W-1:0]  page_number_i,
  output logic                        done_o,
  output logic [bpa_pkg::PAGE_W-1:0]  block_page_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpa_pkg::CNT_W-1:0]   cfg_total_pages_i
);
  import bpa_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: rebuild sweep, order search, word scan, split and merge steps
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cfg_valid_i(cfg_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .cfg_ready_o(cfg_ready_o)
  );

  // datapath: bitmap memory, per-order free counts, working registers
  bpa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .page_count_i     (page_count_i),
    .page_number_i    (page_number_i),
    .cfg_total_pages_i(cfg_total_pages_i),
    .block_page_o     (block_page_o),
    .status_o         (status_o),
    .done_o           (done_o)
  );

endmodule
